FILE: rtl/core/key_event_decoder_macros.svh
// key_event_decoder_macros.svh: assertion macros used by key_event_decoder.
// No dependencies.
`ifndef KEY_EVENT_DECODER_MACROS_SVH
`define KEY_EVENT_DECODER_MACROS_SVH

// implication checked every clock outside reset
`define KED_ASSERT_IMP(label, clk_i, rstn_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KED_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ked_pkg.sv
// ked_pkg: key codes, source codes and character lookup for key_event_decoder.
// No dependencies.
package ked_pkg;

  localparam int unsigned MAX_DEVICES_DEF = 16;

  typedef enum logic [1:0] {
    SRC_ST  = 2'd0,
    SRC_USB = 2'd1,
    SRC_PAD = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    DIR_CENTRE = 2'd0,
    DIR_POS    = 2'd1,
    DIR_NEG    = 2'd2
  } dir_t;

  localparam logic [4:0] K_NONE  = 5'd0;
  localparam logic [4:0] K_UP    = 5'd1;
  localparam logic [4:0] K_DOWN  = 5'd2;
  localparam logic [4:0] K_LEFT  = 5'd3;
  localparam logic [4:0] K_RIGHT = 5'd4;
  localparam logic [4:0] K_ENTER = 5'd5;
  localparam logic [4:0] K_ESC   = 5'd6;
  localparam logic [4:0] K_TAB   = 5'd7;
  localparam logic [4:0] K_BKSP  = 5'd8;
  localparam logic [4:0] K_SPACE = 5'd9;
  localparam logic [4:0] K_HOME  = 5'd10;
  localparam logic [4:0] K_INS   = 5'd11;
  localparam logic [4:0] K_DEL   = 5'd12;
  localparam logic [4:0] K_F1    = 5'd13;
  localparam logic [4:0] K_F10   = 5'd22;
  localparam logic [4:0] K_TICK  = 5'd23;
  localparam logic [4:0] K_SNAP  = 5'd24;
  localparam logic [4:0] K_CHAR  = 5'd25;

  localparam logic [1:0] REG_CENTRE  = 2'd0;
  localparam logic [1:0] REG_ON_THR  = 2'd1;
  localparam logic [1:0] REG_OFF_THR = 2'd2;

  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_ABS = 5'd3;

  typedef struct packed {
    logic       vld;
    logic       is_stick;
    logic       axis;
    logic [4:0] key;
    logic [6:0] ch;
    logic [1:0] src;
  } dec_t;

  // shared typing layout; code is the 7-bit scancode
  function automatic logic [6:0] char_of(input logic [6:0] code, input logic shift,
                                         input logic usb);
    logic [7:0] c;
    c = 8'd0;
    if (code == 7'h29) begin
      c = shift ? 8'h7E : (usb ? 8'h60 : 8'h23);
    end else if (!shift) begin
      case (code)
        7'h02: c = "1"; 7'h03: c = "2"; 7'h04: c = "3"; 7'h05: c = "4";
        7'h06: c = "5"; 7'h07: c = "6"; 7'h08: c = "7"; 7'h09: c = "8";
        7'h0A: c = "9"; 7'h0B: c = "0"; 7'h0C: c = "-"; 7'h0D: c = "=";
        7'h10: c = "q"; 7'h11: c = "w"; 7'h12: c = "e"; 7'h13: c = "r";
        7'h14: c = "t"; 7'h15: c = "y"; 7'h16: c = "u"; 7'h17: c = "i";
        7'h18: c = "o"; 7'h19: c = "p"; 7'h1A: c = "["; 7'h1B: c = "]";
        7'h1E: c = "a"; 7'h1F: c = "s"; 7'h20: c = "d"; 7'h21: c = "f";
        7'h22: c = "g"; 7'h23: c = "h"; 7'h24: c = "j"; 7'h25: c = "k";
        7'h26: c = "l"; 7'h27: c = ";"; 7'h28: c = 8'h27;
        7'h2B: c = 8'h5C; 7'h2C: c = "z"; 7'h2D: c = "x"; 7'h2E: c = "c";
        7'h2F: c = "v"; 7'h30: c = "b"; 7'h31: c = "n"; 7'h32: c = "m";
        7'h33: c = ","; 7'h34: c = "."; 7'h35: c = "/";
        default: c = 8'd0;
      endcase
    end else begin
      case (code)
        7'h02: c = "!"; 7'h03: c = 8'h22; 7'h04: c = "#"; 7'h05: c = "$";
        7'h06: c = "%"; 7'h07: c = "^"; 7'h08: c = "&"; 7'h09: c = "*";
        7'h0A: c = "("; 7'h0B: c = ")"; 7'h0C: c = "_"; 7'h0D: c = "+";
        7'h10: c = "Q"; 7'h11: c = "W"; 7'h12: c = "E"; 7'h13: c = "R";
        7'h14: c = "T"; 7'h15: c = "Y"; 7'h16: c = "U"; 7'h17: c = "I";
        7'h18: c = "O"; 7'h19: c = "P"; 7'h1A: c = "{"; 7'h1B: c = "}";
        7'h1E: c = "A"; 7'h1F: c = "S"; 7'h20: c = "D"; 7'h21: c = "F";
        7'h22: c = "G"; 7'h23: c = "H"; 7'h24: c = "J"; 7'h25: c = "K";
        7'h26: c = "L"; 7'h27: c = ":"; 7'h28: c = "@";
        7'h2B: c = "|"; 7'h2C: c = "Z"; 7'h2D: c = "X"; 7'h2E: c = "C";
        7'h2F: c = "V"; 7'h30: c = "B"; 7'h31: c = "N"; 7'h32: c = "M";
        7'h33: c = "<"; 7'h34: c = ">"; 7'h35: c = "?";
        default: c = 8'd0;
      endcase
    end
    return c[6:0];
  endfunction

endpackage

FILE: rtl/core/key_event_decoder.sv
// key_event_decoder: keyboard and gamepad events to key code and ASCII.
// Uses ked_pkg, ked_ram and key_event_decoder_macros.svh.
// Pipeline: decode into stage 1, then stick RMW into the output register.
// Throughput: one item per cycle while out_ready does not stall the output;
// one stick RAM, same-entry forwarding. Reset: shift flags clear; a clearing
// pass zeroes all 2*MAX_DEVICES stick RAM entries, during which in_ready is low.
module key_event_decoder #(
  parameter int unsigned MAX_DEVICES = ked_pkg::MAX_DEVICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_source,
  input  logic [3:0]  in_device_index,
  input  logic [7:0]  in_acia_status,
  input  logic [7:0]  in_data_byte,
  input  logic [4:0]  in_event_type,
  input  logic [9:0]  in_event_code,
  input  logic signed [15:0] in_event_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_key,
  output logic [6:0]  out_character,
  output logic [1:0]  out_event_source
);
  import ked_pkg::*;
  `include "key_event_decoder_macros.svh"

  localparam int unsigned DEPTH = 2 * MAX_DEVICES;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [15:0] centre_r;
  logic [14:0]        on_thr_r, off_thr_r;
  logic               st_shift_r, usb_shift_r;
  logic [CW-1:0]      clr_cnt_r;
  logic               clr_done;

  // stage 1 (decoded) and output register
  dec_t               s1_r, s1_nxt;
  logic [AW-1:0]      s1_idx_r;
  logic signed [15:0] s1_val_r;
  logic               out_valid_r;
  logic [4:0]         out_key_r;
  logic [6:0]         out_ch_r;
  logic [1:0]         out_src_r;

  logic               adv, s1_take, in_xfer;
  logic [AW-1:0]      rd_idx;
  logic [1:0]         ram_rdata;
  logic               fwd_vld_r;
  logic [1:0]         fwd_dir_r;
  logic [1:0]         cur_dir, new_dir;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [1:0]         wr_data;
  logic signed [17:0] dlt, on_s, off_s;

  assign clr_done = (clr_cnt_r == CW'(DEPTH));
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = clr_done && adv;
  assign in_xfer  = in_valid && in_ready;
  assign s1_take  = adv && s1_r.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r  <= -16'sd1;
      on_thr_r  <= 15'd16383;
      off_thr_r <= 15'd11468;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTRE:  centre_r  <= cfg_data;
        REG_ON_THR:  on_thr_r  <= cfg_data[14:0];
        REG_OFF_THR: off_thr_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // decode stage
  always_comb begin
    logic [6:0] sc;
    logic [4:0] k;
    logic [6:0] c;
    logic [9:0] cd;
    logic       rel;
    s1_nxt = '0;
    k  = K_NONE;
    c  = 7'd0;
    sc = in_data_byte[6:0];
    rel = in_data_byte[7];
    cd = in_event_code;
    s1_nxt.vld = in_xfer;
    s1_nxt.src = in_source;
    case (in_source)
      SRC_ST: begin
        if (in_acia_status[0] && (in_acia_status[6:4] == 3'd0) && !rel &&
            sc != 7'h2A && sc != 7'h36) begin
          case (sc)
            7'h01: k = K_ESC;
            7'h0E: k = K_BKSP;
            7'h0F: k = K_TAB;
            7'h1C, 7'h72: k = K_ENTER;
            7'h39: begin k = K_SPACE; c = 7'h20; end
            7'h48: k = K_UP;
            7'h50: k = K_DOWN;
            7'h4B: k = K_LEFT;
            7'h4D: k = K_RIGHT;
            7'h47: k = K_HOME;
            7'h52: k = K_INS;
            7'h53: k = K_DEL;
            7'h62: k = K_SNAP;
            default: begin
              if (sc inside {[7'h3B:7'h44]}) begin
                k = K_F1 + 5'(sc - 7'h3B);
              end else begin
                c = char_of(sc, st_shift_r, 1'b0);
                k = (c != 7'd0) ? K_CHAR : K_NONE;
              end
            end
          endcase
        end
      end
      SRC_USB: begin
        if (in_event_type == EV_KEY && cd != 10'd42 && cd != 10'd54 &&
            (in_event_value == 16'sd1 || in_event_value == 16'sd2)) begin
          case (cd)
            10'd1:  k = K_ESC;
            10'd14: k = K_BKSP;
            10'd15: k = K_TAB;
            10'd28, 10'd96: k = K_ENTER;
            10'd57: begin k = K_SPACE; c = 7'h20; end
            10'd103: k = K_UP;
            10'd108: k = K_DOWN;
            10'd105: k = K_LEFT;
            10'd106: k = K_RIGHT;
            10'd102: k = K_HOME;
            10'd110: k = K_INS;
            10'd111: k = K_DEL;
            10'd88:  k = K_SNAP;
            default: begin
              if (cd inside {[10'd59:10'd68]}) begin
                k = K_F1 + 5'(cd - 10'd59);
              end else if (cd < 10'd128) begin
                c = char_of(cd[6:0], usb_shift_r, 1'b1);
                k = (c != 7'd0) ? K_CHAR : K_NONE;
              end
            end
          endcase
        end
      end
      SRC_PAD: begin
        if (32'(in_device_index) < MAX_DEVICES) begin
          if (in_event_type == EV_ABS) begin
            if (cd == 10'h10) begin
              k = (in_event_value == 16'sd0) ? K_NONE :
                  (in_event_value < 0 ? K_LEFT : K_RIGHT);
            end else if (cd == 10'h11) begin
              k = (in_event_value == 16'sd0) ? K_NONE :
                  (in_event_value < 0 ? K_UP : K_DOWN);
            end else if (cd == 10'd0 || cd == 10'd1 || cd == 10'd3 || cd == 10'd4) begin
              s1_nxt.is_stick = 1'b1;
              s1_nxt.axis     = (cd == 10'd1 || cd == 10'd4);
            end
          end else if (in_event_type == EV_KEY && in_event_value == 16'sd1) begin
            case (cd)
              10'h220: k = K_UP;
              10'h221: k = K_DOWN;
              10'h222: k = K_LEFT;
              10'h223: k = K_RIGHT;
              10'h130, 10'h120, 10'h121, 10'h123, 10'h151, 10'h100: k = K_ENTER;
              10'h131, 10'h122, 10'h124, 10'h101: k = K_ESC;
              10'h133, 10'h13B, 10'h13C, 10'h13A: k = K_F10;
              10'h134: k = K_TICK;
              default: k = K_NONE;
            endcase
          end
        end
      end
      default: s1_nxt.src = SRC_ST;
    endcase
    s1_nxt.key = k;
    s1_nxt.ch  = (k == K_NONE) ? 7'd0 : c;
  end

  assign rd_idx = AW'({in_device_index, s1_nxt.axis});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_shift_r  <= 1'b0;
      usb_shift_r <= 1'b0;
    end else if (in_xfer) begin
      if (in_source == SRC_ST && in_acia_status[0] && in_acia_status[6:4] == 3'd0 &&
          (in_data_byte[6:0] == 7'h2A || in_data_byte[6:0] == 7'h36)) begin
        st_shift_r <= !in_data_byte[7];
      end
      if (in_source == SRC_USB && in_event_type == EV_KEY &&
          (in_event_code == 10'd42 || in_event_code == 10'd54)) begin
        usb_shift_r <= (in_event_value != 16'sd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (adv) begin
      s1_r.vld <= s1_nxt.vld;
    end
    if (adv) begin
      s1_r.is_stick <= s1_nxt.is_stick;
      s1_r.axis     <= s1_nxt.axis;
      s1_r.key      <= s1_nxt.key;
      s1_r.ch       <= s1_nxt.ch;
      s1_r.src      <= s1_nxt.src;
      s1_idx_r      <= rd_idx;
      s1_val_r      <= in_event_value;
    end
  end

  // stick state RMW in stage 1; forward a same-entry write made at its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (adv) begin
      fwd_vld_r <= wr_en && (wr_addr == rd_idx);
    end
    if (adv) begin
      fwd_dir_r <= wr_data;
    end
  end

  assign cur_dir = fwd_vld_r ? fwd_dir_r : ram_rdata;
  assign dlt   = 18'(s1_val_r) - 18'(centre_r);
  assign on_s  = 18'({1'b0, on_thr_r});
  assign off_s = 18'({1'b0, off_thr_r});

  always_comb begin
    case (cur_dir)
      DIR_POS: new_dir = (dlt < off_s) ? ((dlt <= -on_s) ? DIR_NEG : DIR_CENTRE) : DIR_POS;
      DIR_NEG: new_dir = (dlt > -off_s) ? ((dlt >= on_s) ? DIR_POS : DIR_CENTRE) : DIR_NEG;
      default: new_dir = (dlt >= on_s) ? DIR_POS : ((dlt <= -on_s) ? DIR_NEG : DIR_CENTRE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign wr_en   = !clr_done || (s1_take && s1_r.is_stick && new_dir != cur_dir);
  assign wr_addr = clr_done ? s1_idx_r : clr_cnt_r[AW-1:0];
  assign wr_data = clr_done ? new_dir : DIR_CENTRE;

  ked_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_stick_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (adv),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_r.vld;
    end
    if (adv) begin
      out_src_r <= s1_r.src;
      if (s1_r.is_stick) begin
        out_ch_r <= 7'd0;
        if (new_dir == cur_dir || new_dir == DIR_CENTRE) begin
          out_key_r <= K_NONE;
        end else if (new_dir == DIR_NEG) begin
          out_key_r <= s1_r.axis ? K_UP : K_LEFT;
        end else begin
          out_key_r <= s1_r.axis ? K_DOWN : K_RIGHT;
        end
      end else begin
        out_key_r <= s1_r.key;
        out_ch_r  <= s1_r.ch;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key          = out_key_r;
  assign out_character    = out_ch_r;
  assign out_event_source = out_src_r;

  `KED_ASSERT_IMP(a_no_input_in_clear, clk, rst_n, !clr_done, !in_ready, "input taken during clear")
  `KED_ASSERT_IMP(a_char_needs_key, clk, rst_n, out_valid && out_character != 7'd0,
    out_key == K_CHAR || out_key == K_SPACE, "character without char key")
  `KED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_key), "result lost under stall")
  `KED_ASSERT_IMP(a_stick_dir_code, clk, rst_n, wr_en, wr_data != 2'd3, "bad stick code")

endmodule

FILE: rtl/core/ked_ram.sv
// ked_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module ked_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/key_event_decoder_tb.sv
// key_event_decoder_tb: self-checking testbench for key_event_decoder.
// Uses ked_pkg; a scoreboard class predicts key, character and source per input
// transfer and checks the results in order.
module key_event_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ked_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_DEVICES    = 16;

  typedef struct {
    logic [4:0] key;
    logic [6:0] ch;
    logic [1:0] src;
  } key_result_t;

  class key_scoreboard;
    key_result_t pending[$];
    int          mismatches;
    int          centre;
    int          on_thr;
    int          off_thr;
    bit          acia_shift;
    bit          usb_shift;
    dir_t        stick_dir[NUM_DEVICES * 2];
    string       row_lo[4];
    string       row_hi[4];
    int          row_first[4];

    function new();
      row_first = '{8'h02, 8'h10, 8'h1E, 8'h2B};
      row_lo = '{"1234567890-=", "qwertyuiop[]", "asdfghjkl;'", "\\zxcvbnm,./"};
      row_hi = '{"!\"#$%^&*()_+", "QWERTYUIOP{}", "ASDFGHJKL:@", "|ZXCVBNM<>?"};
      mismatches = 0;
      centre = -1;
      on_thr = 16383;
      off_thr = 11468;
      acia_shift = 0;
      usb_shift = 0;
      foreach (stick_dir[i]) stick_dir[i] = DIR_CENTRE;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_CENTRE:  centre = $signed(data);
        REG_ON_THR:  on_thr = data[14:0];
        REG_OFF_THR: off_thr = data[14:0];
        default: ;
      endcase
    endfunction

    function logic [6:0] glyph(int code, bit shift, bit usb);
      if (code == 'h29) return shift ? 7'h7E : (usb ? 7'h60 : 7'h23);
      for (int i = 0; i < 4; i++) begin
        if (code >= row_first[i] && code < row_first[i] + row_lo[i].len())
          return 7'(shift ? row_hi[i][code - row_first[i]] : row_lo[i][code - row_first[i]]);
      end
      return 7'd0;
    endfunction

    // shared tail of both keyboard maps: F-keys then typing keys
    function logic [4:0] typing_key(int code, int f_base, bit shift, bit usb,
                                    output logic [6:0] ch);
      ch = 7'd0;
      if (code >= f_base && code <= f_base + 9) return K_F1 + 5'(code - f_base);
      ch = glyph(code, shift, usb);
      return (ch != 0) ? K_CHAR : K_NONE;
    endfunction

    function logic [4:0] acia_key(int sc, output logic [6:0] ch);
      ch = 7'd0;
      case (sc)
        'h01: return K_ESC;
        'h0E: return K_BKSP;
        'h0F: return K_TAB;
        'h1C, 'h72: return K_ENTER;
        'h39: begin ch = 7'h20; return K_SPACE; end
        'h48: return K_UP;
        'h50: return K_DOWN;
        'h4B: return K_LEFT;
        'h4D: return K_RIGHT;
        'h47: return K_HOME;
        'h52: return K_INS;
        'h53: return K_DEL;
        'h62: return K_SNAP;
        default: return typing_key(sc, 'h3B, acia_shift, 0, ch);
      endcase
    endfunction

    function logic [4:0] usb_key(int code, output logic [6:0] ch);
      ch = 7'd0;
      case (code)
        1: return K_ESC;
        14: return K_BKSP;
        15: return K_TAB;
        28, 96: return K_ENTER;
        57: begin ch = 7'h20; return K_SPACE; end
        103: return K_UP;
        108: return K_DOWN;
        105: return K_LEFT;
        106: return K_RIGHT;
        102: return K_HOME;
        110: return K_INS;
        111: return K_DEL;
        88: return K_SNAP;
        default: return typing_key(code, 59, usb_shift, 1, ch);
      endcase
    endfunction

    function logic [4:0] button_key(int code);
      case (code)
        'h220: return K_UP;
        'h221: return K_DOWN;
        'h222: return K_LEFT;
        'h223: return K_RIGHT;
        'h130, 'h120, 'h121, 'h123, 'h151, 'h100: return K_ENTER;
        'h131, 'h122, 'h124, 'h101: return K_ESC;
        'h133, 'h13B, 'h13C, 'h13A: return K_F10;
        'h134: return K_TICK;
        default: return K_NONE;
      endcase
    endfunction

    function dir_t stick_step(dir_t cur, int value);
      int d;
      d = value - centre;
      if (cur == DIR_POS) return d < off_thr ? (d <= -on_thr ? DIR_NEG : DIR_CENTRE) : DIR_POS;
      if (cur == DIR_NEG) return d > -off_thr ? (d >= on_thr ? DIR_POS : DIR_CENTRE) : DIR_NEG;
      if (d >= on_thr) return DIR_POS;
      if (d <= -on_thr) return DIR_NEG;
      return DIR_CENTRE;
    endfunction

    function logic [4:0] pad_key(int dev, int typ, int code, int value);
      int   axis;
      int   idx;
      dir_t nxt;
      if (dev >= NUM_DEVICES) return K_NONE;
      if (typ == EV_ABS) begin
        if (code == 'h10) return value == 0 ? K_NONE : (value < 0 ? K_LEFT : K_RIGHT);
        if (code == 'h11) return value == 0 ? K_NONE : (value < 0 ? K_UP : K_DOWN);
        if (code == 0 || code == 1 || code == 3 || code == 4) begin
          axis = (code == 0 || code == 3) ? 0 : 1;
          idx = dev * 2 + axis;
          nxt = stick_step(stick_dir[idx], value);
          if (nxt == stick_dir[idx]) return K_NONE;
          stick_dir[idx] = nxt;
          if (nxt == DIR_NEG) return axis ? K_UP : K_LEFT;
          if (nxt == DIR_POS) return axis ? K_DOWN : K_RIGHT;
        end
        return K_NONE;
      end
      if (typ == EV_KEY && value == 1) return button_key(code);
      return K_NONE;
    endfunction

    function void note_event(logic [1:0] src, logic [3:0] dev, logic [7:0] status,
                             logic [7:0] data, logic [4:0] typ, logic [9:0] code,
                             logic signed [15:0] value);
      key_result_t r;
      int          v;
      v = value;
      r.key = K_NONE;
      r.ch = 7'd0;
      r.src = src;
      case (src)
        SRC_ST: begin
          if (status[0] && status[6:4] == 3'd0) begin
            if (data[6:0] == 7'h2A || data[6:0] == 7'h36) acia_shift = !data[7];
            else if (!data[7]) r.key = acia_key(data[6:0], r.ch);
          end
        end
        SRC_USB: begin
          if (typ == EV_KEY) begin
            if (code == 42 || code == 54) usb_shift = (v != 0);
            else if (v == 1 || v == 2) r.key = usb_key(code, r.ch);
          end
        end
        SRC_PAD: r.key = pad_key(dev, typ, code, v);
        default: r.src = SRC_ST;
      endcase
      if (r.key == K_NONE) r.ch = 7'd0;
      pending.push_back(r);
    endfunction

    function void check_result(logic [4:0] key, logic [6:0] ch, logic [1:0] src);
      key_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result key=%0d ch=%0h src=%0d", $realtime, key, ch, src);
        return;
      end
      e = pending.pop_front();
      if (key !== e.key || ch !== e.ch || src !== e.src) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp key=%0d ch=%0h src=%0d got key=%0d ch=%0h src=%0d",
                   $realtime, e.key, e.ch, e.src, key, ch, src);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_source = '0;
  logic [3:0]  in_device_index = '0;
  logic [7:0]  in_acia_status = '0;
  logic [7:0]  in_data_byte = '0;
  logic [4:0]  in_event_type = '0;
  logic [9:0]  in_event_code = '0;
  logic signed [15:0] in_event_value = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [4:0]  out_key;
  logic [6:0]  out_character;
  logic [1:0]  out_event_source;

  key_scoreboard sb = new();
  bit            no_idle = 0;
  int            idle_cycles = 0;
  int            sink_hold = 0;

  key_event_decoder u_top (.*);

  always #6 clk = ~clk;

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_event(in_source, in_device_index, in_acia_status, in_data_byte,
                      in_event_type, in_event_code, in_event_value);
      if (out_valid && out_ready) sb.check_result(out_key, out_character, out_event_source);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 0;
    end else begin
      sink_hold <= gap_len();
      out_ready <= 1;
    end
  end

  task automatic send(logic [1:0] src, logic [3:0] dev, logic [7:0] status,
                      logic [7:0] data, logic [4:0] typ, logic [9:0] code,
                      logic [15:0] value);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_source <= src;
    in_device_index <= dev;
    in_acia_status <= status;
    in_data_byte <= data;
    in_event_type <= typ;
    in_event_code <= code;
    in_event_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [15:0] axis_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom);
    if (r < 5) return 16'(sb.centre + sb.on_thr + $signed($urandom_range(0, 4)) - 2);
    if (r < 7) return 16'(sb.centre - sb.on_thr + $signed($urandom_range(0, 4)) - 2);
    if (r < 8) return 16'(sb.centre + sb.off_thr + $signed($urandom_range(0, 4)) - 2);
    if (r < 9) return 16'(sb.centre - sb.off_thr + $signed($urandom_range(0, 4)) - 2);
    return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
  endfunction

  task automatic random_item();
    int          r;
    logic [9:0]  code;
    logic [15:0] value;
    logic [7:0]  status;
    r = $urandom_range(0, 99);
    status = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h01 | (8'($urandom) & 8'h8E);
    if (r < 25) begin
      send(SRC_ST, 4'($urandom), status, ($urandom_range(0, 5) == 0) ? 8'h2A : 8'($urandom),
           5'($urandom), 10'($urandom), 16'($urandom));
    end else if (r < 50) begin
      code = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 127));
      if ($urandom_range(0, 6) == 0) code = $urandom_range(0, 1) ? 10'd42 : 10'd54;
      value = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
      send(SRC_USB, 4'($urandom), 8'($urandom), 8'($urandom),
           ($urandom_range(0, 7) == 0) ? 5'($urandom) : EV_KEY, code, value);
    end else if (r < 75) begin
      code = 10'($urandom_range(0, 4));
      if (code == 2) code = 10'h10 + 10'($urandom_range(0, 1));
      send(SRC_PAD, 4'($urandom), 8'($urandom), 8'($urandom),
           ($urandom_range(0, 9) == 0) ? 5'($urandom) : EV_ABS, code,
           (code >= 10'h10) ? 16'($signed($urandom_range(0, 2)) - 1) : axis_value());
    end else if (r < 95) begin
      case ($urandom_range(0, 4))
        0: code = 10'h220 + 10'($urandom_range(0, 3));
        1: code = 10'h120 + 10'($urandom_range(0, 4));
        2: code = 10'h130 + 10'($urandom_range(0, 12));
        3: code = $urandom_range(0, 1) ? 10'h100 + 10'($urandom_range(0, 1)) : 10'h151;
        default: code = 10'($urandom);
      endcase
      send(SRC_PAD, 4'($urandom), 8'($urandom), 8'($urandom),
           ($urandom_range(0, 7) == 0) ? 5'($urandom) : EV_KEY, code,
           ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2)));
    end else begin
      send(2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
           10'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      random_item();
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: serial keyboard
    send(SRC_ST, 0, 8'h01, 8'h10, 0, 0, 0);
    send(SRC_ST, 0, 8'h00, 8'h10, 0, 0, 0);
    send(SRC_ST, 0, 8'h71, 8'h10, 0, 0, 0);
    send(SRC_ST, 0, 8'h01, 8'h2A, 0, 0, 0);
    send(SRC_ST, 0, 8'h01, 8'h03, 0, 0, 0);
    send(SRC_ST, 0, 8'h01, 8'h29, 0, 0, 0);
    send(SRC_ST, 0, 8'h01, 8'hAA, 0, 0, 0);
    send(SRC_ST, 0, 8'h8F, 8'h29, 0, 0, 0);
    send(SRC_ST, 0, 8'h01, 8'hFF, 0, 0, 0);
    send(SRC_ST, 0, 8'h01, 8'h44, 0, 0, 0);
    // directed: USB keyboard
    send(SRC_USB, 0, 0, 0, EV_KEY, 10'd54, 16'd1);
    send(SRC_USB, 0, 0, 0, EV_KEY, 10'd30, 16'd2);
    send(SRC_USB, 0, 0, 0, EV_KEY, 10'd54, 16'd0);
    send(SRC_USB, 0, 0, 0, EV_KEY, 10'd41, 16'd1);
    send(SRC_USB, 0, 0, 0, EV_KEY, 10'd57, 16'd0);
    send(SRC_USB, 0, 0, 0, EV_KEY, 10'd1023, 16'd1);
    // directed: gamepad hat, buttons, sticks, unused source
    send(SRC_PAD, 4'd15, 0, 0, EV_ABS, 10'h10, 16'h0000);
    send(SRC_PAD, 4'd15, 0, 0, EV_ABS, 10'h11, 16'h8000);
    send(SRC_PAD, 4'd3, 0, 0, EV_KEY, 10'h134, 16'd1);
    send(SRC_PAD, 4'd3, 0, 0, EV_ABS, 10'd0, 16'h7FFF);
    send(SRC_PAD, 4'd3, 0, 0, EV_ABS, 10'd3, 16'h7FFF);
    send(SRC_PAD, 4'd3, 0, 0, EV_ABS, 10'd0, 16'h0000);
    send(SRC_PAD, 4'd3, 0, 0, EV_ABS, 10'd4, 16'h8000);
    send(2'd3, 4'd15, 8'hFF, 8'hFF, 5'h1F, 10'h3FF, 16'hFFFF);
    drain();

    random_phase(300);

    cfg_write(REG_CENTRE, 16'h8000);
    cfg_write(REG_ON_THR, 16'h0000);
    cfg_write(REG_OFF_THR, 16'h0000);
    no_idle = 1;
    random_phase(300);
    no_idle = 0;

    cfg_write(REG_CENTRE, 16'h7FFF);
    cfg_write(REG_ON_THR, 16'h7FFF);
    cfg_write(REG_OFF_THR, 16'h7FFF);
    random_phase(300);

    cfg_write(REG_CENTRE, 16'h0000);
    cfg_write(REG_ON_THR, 16'd1000);
    cfg_write(REG_OFF_THR, 16'd3000);
    random_phase(300);

    cfg_write(REG_CENTRE, 16'($urandom_range(0, 2000)) - 16'd1000);
    cfg_write(REG_ON_THR, 16'($urandom_range(2000, 20000)));
    cfg_write(REG_OFF_THR, 16'hFFFF);
    random_phase(300);

    cfg_write(REG_CENTRE, 16'hFFFF);
    cfg_write(REG_ON_THR, 16'd16383);
    cfg_write(REG_OFF_THR, 16'd11468);
    random_phase(300);

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
